>>> rtl/core/jsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Result status codes, job format passed from decoder to expander, sizes.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Depth of the job queue between decoder and expander
  localparam int unsigned JsuQueueDepth = 4;

  // Status reported with each result transaction
  typedef enum logic [2:0] {
    ST_BYTE       = 3'd0,
    ST_CLOSED     = 3'd1,
    ST_UNTERM_ESC = 3'd2,
    ST_TRUNC_U    = 3'd3,
    ST_BAD_HEX    = 3'd4,
    ST_BAD_ESC    = 3'd5,
    ST_UNTERM     = 3'd6
  } status_e;

  // What the expander has to do with one queued job
  typedef enum logic [1:0] {
    JOB_BYTE   = 2'd0,  // one literal byte in data[7:0]
    JOB_STATUS = 2'd1,  // one final status, no byte
    JOB_CP     = 2'd2   // code point in data, one to three UTF-8 bytes
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [15:0] data;
    status_e     status;
  } job_t;

  // UTF-8 encoding thresholds and prefixes
  localparam logic [15:0] Utf8TwoByteMin   = 16'h0080;
  localparam logic [15:0] Utf8ThreeByteMin = 16'h0800;
  localparam logic [7:0]  Utf8Lead2        = 8'hC0;
  localparam logic [7:0]  Utf8Lead3        = 8'hE0;
  localparam logic [7:0]  Utf8Cont         = 8'h80;

endpackage : jsu_pkg
`default_nettype wire

>>> rtl/core/json_string_unescape_utf8.sv
`default_nettype none
// Path: an accepted input transaction writes its job into the queue; the
//   expander then loads results from it into the output register.
// Throughput: one input byte per cycle while not full; the expander emits one
//   result per cycle while popped and fed; a \u escape's final digit expands
//   to up to three results. full is high while QueueDepth jobs are queued.
// Reset: asynchronous, active low; clears string state, queue and output valid.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string body unescaper with UTF-8 output
// Decoder front end, job queue and result expander in sequence.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 import jsu_pkg::*; #(
  parameter int unsigned QueueDepth = JsuQueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       start_req_i,
  input  wire logic       end_of_text_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      status_o,
  output logic            last_o
);

  logic job_push, q_full, q_avail, q_pop;
  job_t job_in, job_out;

  assign full = q_full;

  jsu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .q_full_i     (q_full),
    .in_byte_i    (in_byte_i),
    .start_req_i  (start_req_i),
    .end_of_text_i(end_of_text_i),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  jsu_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (job_push),
    .wr_data_i  (job_in),
    .full_o     (q_full),
    .rd_en_i    (q_pop),
    .rd_data_o  (job_out),
    .not_empty_o(q_avail)
  );

  jsu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job_out),
    .job_avail_i(q_avail),
    .job_pop_o  (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_byte_o (out_byte_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

  // Decoder never writes a job into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(job_push && q_full)) else $error("job written into full queue");

  // A multi-byte sequence continues without a gap once its first byte is taken
  a_seq_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> !empty) else $error("UTF-8 sequence broken");

  // Final statuses carry no byte and end the transaction group
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_BYTE) |-> (last_o && out_byte_o == 8'h00))
    else $error("status result malformed");

  // Results only come from queued jobs
  a_pop_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_avail) else $error("job taken from empty queue");

endmodule : json_string_unescape_utf8
`default_nettype wire

>>> rtl/core/jsu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front: escape decoder
// Tracks the string state one input byte per cycle, unless the queue is full,
// and turns each input transaction into at most one job for the expander.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic       q_full_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       start_req_i,
  input  wire logic       end_of_text_i,
  output logic            job_push_o,
  output job_t            job_o
);

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_TEXT = 4'b0010,
    MODE_ESC  = 4'b0100,
    MODE_HEX  = 4'b1000
  } mode_e;

  // {invalid, value}: invalid set for any non-hex byte
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b1_0000;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  mode_e       mode_q, mode_d, mode_eff;
  logic [1:0]  hcnt_q, hcnt_d, hcnt_eff;
  logic [15:0] cp_q, cp_d, cp_eff, cp_next;
  logic        bad_q, bad_d, bad_eff, bad_next;
  logic [4:0]  hex;
  logic        accept;

  assign accept = push_i & ~q_full_i;
  assign hex    = hex_decode(in_byte_i);

  // Start request gives a fresh string before the byte is handled
  always_comb begin
    mode_eff = start_req_i ? MODE_TEXT : mode_q;
    hcnt_eff = start_req_i ? 2'd0 : hcnt_q;
    cp_eff   = start_req_i ? 16'h0 : cp_q;
    bad_eff  = start_req_i ? 1'b0 : bad_q;
  end

  assign cp_next  = {cp_eff[11:0], hex[4] ? 4'h0 : hex[3:0]};
  assign bad_next = bad_eff | hex[4];

  // Next state and job classification
  always_comb begin
    mode_d      = mode_q;
    hcnt_d      = hcnt_q;
    cp_d        = cp_q;
    bad_d       = bad_q;
    job_push_o  = 1'b0;
    job_o.kind   = JOB_BYTE;
    job_o.data   = {8'h00, in_byte_i};
    job_o.status = ST_BYTE;
    if (accept) begin
      mode_d = mode_eff;
      hcnt_d = hcnt_eff;
      cp_d   = cp_eff;
      bad_d  = bad_eff;
      if (mode_eff != MODE_IDLE && end_of_text_i) begin
        job_push_o   = 1'b1;
        job_o.kind   = JOB_STATUS;
        mode_d       = MODE_IDLE;
        case (mode_eff)
          MODE_TEXT: job_o.status = ST_UNTERM;
          MODE_ESC:  job_o.status = ST_UNTERM_ESC;
          default:   job_o.status = ST_TRUNC_U;
        endcase
      end else begin
        case (mode_eff)
          MODE_TEXT: begin
            if (in_byte_i == 8'h22) begin
              job_push_o   = 1'b1;
              job_o.kind   = JOB_STATUS;
              job_o.status = ST_CLOSED;
              mode_d       = MODE_IDLE;
            end else if (in_byte_i == 8'h5C) begin
              mode_d = MODE_ESC;
            end else begin
              job_push_o = 1'b1;
            end
          end
          MODE_ESC: begin
            job_push_o = 1'b1;
            mode_d     = MODE_TEXT;
            case (in_byte_i)
              8'h22, 8'h5C, 8'h2F: job_o.data = {8'h00, in_byte_i};
              8'h62: job_o.data = 16'h0008;
              8'h66: job_o.data = 16'h000C;
              8'h6E: job_o.data = 16'h000A;
              8'h72: job_o.data = 16'h000D;
              8'h74: job_o.data = 16'h0009;
              8'h75: begin
                // \u: begin collecting four hex digits
                job_push_o = 1'b0;
                mode_d     = MODE_HEX;
                hcnt_d     = 2'd0;
                cp_d       = 16'h0;
                bad_d      = 1'b0;
              end
              default: begin
                job_o.kind   = JOB_STATUS;
                job_o.status = ST_BAD_ESC;
                mode_d       = MODE_IDLE;
              end
            endcase
          end
          MODE_HEX: begin
            cp_d  = cp_next;
            bad_d = bad_next;
            if (hcnt_eff == 2'd3) begin
              // fourth digit: emit code point or report a bad digit
              hcnt_d     = 2'd0;
              job_push_o = 1'b1;
              job_o.data = cp_next;
              if (bad_next) begin
                job_o.kind   = JOB_STATUS;
                job_o.status = ST_BAD_HEX;
                mode_d       = MODE_IDLE;
              end else begin
                job_o.kind = JOB_CP;
                mode_d     = MODE_TEXT;
              end
            end else begin
              hcnt_d = hcnt_eff + 2'd1;
            end
          end
          default: ;  // idle: item gives nothing
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      hcnt_q <= 2'd0;
      cp_q   <= 16'h0;
      bad_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      hcnt_q <= hcnt_d;
      cp_q   <= cp_d;
      bad_q  <= bad_d;
    end
  end

endmodule : jsu_front
`default_nettype wire

>>> rtl/core/jsu_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_queue: job queue
// Small register FIFO that decouples the decoder from the expander.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; #(
  parameter int unsigned Depth = JsuQueueDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_en_i,
  input  wire job_t  wr_data_i,
  output logic       full_o,
  input  wire logic  rd_en_i,
  output job_t       rd_data_o,
  output logic       not_empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign not_empty_o = (cnt_q != '0);
  assign do_wr       = wr_en_i & ~full_o;
  assign do_rd       = rd_en_i & not_empty_o;
  assign rd_data_o   = slots_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) slots_q[wr_ptr_q] <= wr_data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_rd) rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (!do_wr && do_rd) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule : jsu_queue
`default_nettype wire

>>> rtl/core/jsu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_back: result expander
// Turns each queued job into one to three result transactions and holds
// the current result in an output register.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire job_t  job_i,
  input  wire logic  job_avail_i,
  output logic       job_pop_o,
  output logic       empty_o,
  input  wire logic  pop_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o,
  output logic       last_o
);

  logic [1:0] idx_q, idx_d;   // byte position within a code point
  logic [1:0] n_last;         // index of the final byte of the job
  logic       valid_q;
  logic [7:0] byte_q, res_byte;
  status_e    status_q;
  logic       last_q, res_last, load;

  // UTF-8 length of the code point, as index of its last byte
  always_comb begin
    if (job_i.data < Utf8TwoByteMin)        n_last = 2'd0;
    else if (job_i.data < Utf8ThreeByteMin) n_last = 2'd1;
    else                                    n_last = 2'd2;
  end

  // Select the byte for the current position
  always_comb begin
    res_byte = job_i.data[7:0];
    res_last = 1'b1;
    case (job_i.kind)
      JOB_STATUS: res_byte = 8'h00;
      JOB_CP: begin
        res_last = (idx_q == n_last);
        case (n_last)
          2'd0: res_byte = job_i.data[7:0];
          2'd1: res_byte = (idx_q == 2'd0) ? (Utf8Lead2 | {3'b000, job_i.data[10:6]})
                                           : (Utf8Cont | {2'b00, job_i.data[5:0]});
          default: begin
            case (idx_q)
              2'd0:    res_byte = Utf8Lead3 | {4'h0, job_i.data[15:12]};
              2'd1:    res_byte = Utf8Cont | {2'b00, job_i.data[11:6]};
              default: res_byte = Utf8Cont | {2'b00, job_i.data[5:0]};
            endcase
          end
        endcase
      end
      default: ;
    endcase
  end

  // Load a new result when the output register is free or being taken
  assign load      = job_avail_i & (~valid_q | pop_i);
  assign job_pop_o = load & res_last;
  assign idx_d     = load ? (res_last ? 2'd0 : idx_q + 2'd1) : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= load | (valid_q & ~pop_i);
      idx_q   <= idx_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= res_byte;
      status_q <= (job_i.kind == JOB_STATUS) ? job_i.status : ST_BYTE;
      last_q   <= res_last;
    end
  end

  assign empty_o    = ~valid_q;
  assign out_byte_o = byte_q;
  assign status_o   = status_q;
  assign last_o     = last_q;

endmodule : jsu_back
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for json_string_unescape_utf8
// Drives string-body bytes through push/full, pops results through empty/pop
// and checks every result against a fixed directed-row result or an internal
// unescape predictor. A directed table comes first, then random strings.
// ----------------------------------------------------------------------------
module tb;
  import jsu_pkg::*;

  localparam logic [7:0] QuoteCh    = 8'h22;
  localparam logic [7:0] BslashCh   = 8'h5C;
  localparam logic [7:0] SlashCh    = 8'h2F;
  localparam int         NumItems   = 180;
  localparam int         HoldCycles = 100;
  localparam int         TailCycles = 20;
  localparam int         MaxReport  = 10;

  // String decode mode of the predictor
  typedef enum logic [1:0] {TM_IDLE, TM_TEXT, TM_ESC, TM_HEX} text_mode_e;

  // How a stimulus row is checked
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_ONE} row_chk_e;

  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       eot;
    row_chk_e   chk;
    logic [7:0] t_data;
    status_e    t_status;
  } stim_row_t;

  // Directed table: rows check the predictor, one fixed result or nothing
  stim_row_t dir_tab [0:27] = '{
    '{"a",      1'b0, 1'b0, CHK_NONE, 8'h00, ST_BYTE},       // idle, ignored
    '{BslashCh, 1'b1, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{"x",      1'b0, 1'b0, CHK_ONE,  8'h00, ST_BAD_ESC},
    '{8'h00,    1'b1, 1'b0, CHK_ONE,  8'h00, ST_BYTE},
    '{8'hFF,    1'b0, 1'b0, CHK_ONE,  8'hFF, ST_BYTE},
    '{BslashCh, 1'b0, 1'b0, CHK_NONE, 8'h00, ST_BYTE},
    '{8'hFF,    1'b0, 1'b1, CHK_ONE,  8'h00, ST_UNTERM_ESC},
    '{QuoteCh,  1'b1, 1'b0, CHK_ONE,  8'h00, ST_CLOSED},
    '{BslashCh, 1'b1, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{"u",      1'b0, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{"0",      1'b0, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{BslashCh, 1'b1, 1'b0, CHK_PRED, 8'h00, ST_BYTE},       // restart in hex
    '{"u",      1'b0, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{"G",      1'b0, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{QuoteCh,  1'b0, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{BslashCh, 1'b0, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{"f",      1'b0, 1'b0, CHK_ONE,  8'h00, ST_BAD_HEX},
    '{BslashCh, 1'b1, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{"u",      1'b0, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{"D",      1'b0, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{"f",      1'b0, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{"F",      1'b0, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{"f",      1'b0, 1'b0, CHK_PRED, 8'h00, ST_BYTE},       // raw surrogate
    '{8'h00,    1'b0, 1'b1, CHK_ONE,  8'h00, ST_UNTERM},
    '{BslashCh, 1'b1, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{"u",      1'b0, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{"1",      1'b0, 1'b0, CHK_PRED, 8'h00, ST_BYTE},
    '{8'h5A,    1'b0, 1'b1, CHK_ONE,  8'h00, ST_TRUNC_U}
  };

  // DUT signals
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       push          = 1'b0;
  logic [7:0] in_byte_i     = 8'h00;
  logic       start_req_i   = 1'b0;
  logic       end_of_text_i = 1'b0;
  logic       pop           = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte_o;
  logic [2:0] status_o;
  logic       last_o;

  // Predictor state
  text_mode_e  str_mode   = TM_IDLE;
  logic [1:0]  hex_cnt    = 2'd0;
  logic [15:0] cp_acc     = 16'h0000;
  logic        hex_bad    = 1'b0;
  result_t     step_res[$];
  result_t     pending_out[$];

  // Run control
  stim_row_t stim_q[$];
  logic      start_next = 1'b0;
  logic      calm       = 1'b0;
  logic      hold_req   = 1'b0;
  int        hold_left  = 0;
  int        n_sent     = 0;
  int        n_fail     = 0;

  // Negedge snapshot of DUT outputs, stable across the next rising edge
  logic    full_q  = 1'b1;
  logic    empty_q = 1'b1;
  result_t got_q;

  json_string_unescape_utf8 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_byte_i     (in_byte_i),
    .start_req_i   (start_req_i),
    .end_of_text_i (end_of_text_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    full_q        = full;
    empty_q       = empty;
    got_q.data    = out_byte_o;
    got_q.status  = status_e'(status_o);
    got_q.last    = last_o;
  end

  function automatic result_t mk_res(input logic [7:0] d, input status_e s, input logic l);
    result_t r;
    r.data   = d;
    r.status = s;
    r.last   = l;
    return r;
  endfunction

  // Append one predicted result of the current step
  function automatic void res_add(input result_t r);
    step_res = {step_res, r};
  endfunction

  // Unescape predictor: one input transaction in, its results into step_res
  function automatic void unescape_step(input logic [7:0] c, input logic st,
                                        input logic eot);
    logic [7:0] b;
    logic [3:0] nib;
    step_res.delete();
    if (st) begin
      str_mode = TM_TEXT;
      hex_cnt  = 2'd0;
      cp_acc   = 16'h0000;
      hex_bad  = 1'b0;
    end
    if (str_mode == TM_IDLE) return;

    // End of text: status depends on where the string was cut
    if (eot) begin
      case (str_mode)
        TM_TEXT: res_add(mk_res(8'h00, ST_UNTERM, 1'b1));
        TM_ESC:  res_add(mk_res(8'h00, ST_UNTERM_ESC, 1'b1));
        default: res_add(mk_res(8'h00, ST_TRUNC_U, 1'b1));
      endcase
      str_mode = TM_IDLE;
      return;
    end

    case (str_mode)
      TM_TEXT: begin
        if (c == QuoteCh) begin
          res_add(mk_res(8'h00, ST_CLOSED, 1'b1));
          str_mode = TM_IDLE;
        end else if (c == BslashCh) begin
          str_mode = TM_ESC;
        end else begin
          res_add(mk_res(c, ST_BYTE, 1'b1));
        end
      end
      TM_ESC: begin
        b = 8'h00;
        case (c)
          QuoteCh, BslashCh, SlashCh: b = c;
          "b": b = 8'h08;
          "f": b = 8'h0C;
          "n": b = 8'h0A;
          "r": b = 8'h0D;
          "t": b = 8'h09;
          "u": begin
            str_mode = TM_HEX;
            hex_cnt  = 2'd0;
            cp_acc   = 16'h0000;
            hex_bad  = 1'b0;
          end
          default: begin
            res_add(mk_res(8'h00, ST_BAD_ESC, 1'b1));
            str_mode = TM_IDLE;
          end
        endcase
        if (str_mode == TM_ESC) begin
          res_add(mk_res(b, ST_BYTE, 1'b1));
          str_mode = TM_TEXT;
        end
      end
      default: begin
        // Four bytes always taken; a non-hex byte counts as zero and is flagged
        if (c >= "0" && c <= "9") begin
          nib = 4'(c - "0");
        end else if (c >= "a" && c <= "f") begin
          nib = 4'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
          nib = 4'(c - "A" + 8'd10);
        end else begin
          nib     = 4'h0;
          hex_bad = 1'b1;
        end
        cp_acc = {cp_acc[11:0], nib};
        if (hex_cnt == 2'd3) begin
          hex_cnt = 2'd0;
          if (hex_bad) begin
            res_add(mk_res(8'h00, ST_BAD_HEX, 1'b1));
            str_mode = TM_IDLE;
          end else begin
            str_mode = TM_TEXT;
            if (cp_acc < 16'h0080) begin
              res_add(mk_res(cp_acc[7:0], ST_BYTE, 1'b1));
            end else if (cp_acc < 16'h0800) begin
              res_add(mk_res({3'b110, cp_acc[10:6]}, ST_BYTE, 1'b0));
              res_add(mk_res({2'b10, cp_acc[5:0]}, ST_BYTE, 1'b1));
            end else begin
              res_add(mk_res({4'b1110, cp_acc[15:12]}, ST_BYTE, 1'b0));
              res_add(mk_res({2'b10, cp_acc[11:6]}, ST_BYTE, 1'b0));
              res_add(mk_res({2'b10, cp_acc[5:0]}, ST_BYTE, 1'b1));
            end
          end
        end else begin
          hex_cnt = hex_cnt + 2'd1;
        end
      end
    endcase
  endfunction

  // Random stimulus builders
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'("0") + 8'(v);
    return ($urandom_range(1) ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
  endfunction

  task automatic add(input logic [7:0] b, input logic e);
    stim_row_t r;
    r = '{b, start_next, e, CHK_PRED, 8'h00, ST_BYTE};
    stim_q = {stim_q, r};
    start_next = 1'b0;
  endtask

  task automatic add_plain();
    logic [7:0] b;
    do begin
      b = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(32, 126));
    end while (b == QuoteCh || b == BslashCh);
    add(b, 1'b0);
  endtask

  task automatic add_escape();
    logic [7:0] b;
    case ($urandom_range(7))
      0:       b = QuoteCh;
      1:       b = BslashCh;
      2:       b = SlashCh;
      3:       b = "b";
      4:       b = "f";
      5:       b = "n";
      6:       b = "r";
      default: b = "t";
    endcase
    add(BslashCh, 1'b0);
    add(b, 1'b0);
  endtask

  task automatic add_u();
    logic [15:0] cp;
    case ($urandom_range(3))
      0:       cp = 16'($urandom_range(0, 16'h007F));
      1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
      2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
      default: cp = 16'hD800 + 16'($urandom_range(0, 16'h07FF));
    endcase
    add(BslashCh, 1'b0);
    add("u", 1'b0);
    add(hex_char(cp[15:12]), 1'b0);
    add(hex_char(cp[11:8]), 1'b0);
    add(hex_char(cp[7:4]), 1'b0);
    add(hex_char(cp[3:0]), 1'b0);
  endtask

  // One string: mostly well formed, some broken, some raw noise
  task automatic gen_string();
    int         kind;
    int         pos;
    logic [7:0] b;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      repeat ($urandom_range(1, 6)) begin
        start_next = ($urandom_range(7) == 0);
        add(8'($urandom_range(255)), $urandom_range(7) == 0);
      end
      return;
    end
    start_next = 1'b1;
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: add_plain();
        5, 6:          add_escape();
        default:       add_u();
      endcase
    end
    if (kind < 70) begin
      if ($urandom_range(4) != 0) add(QuoteCh, 1'b0);
      else add(8'($urandom_range(255)), 1'b1);
      return;
    end
    case ($urandom_range(4))
      0: begin
        do b = 8'($urandom_range(255));
        while (b == QuoteCh || b == BslashCh || b == SlashCh || b == "b" || b == "f" ||
               b == "n" || b == "r" || b == "t" || b == "u");
        add(BslashCh, 1'b0);
        add(b, 1'b0);
      end
      1: begin
        add(BslashCh, 1'b0);
        add("u", 1'b0);
        pos = $urandom_range(3);
        for (int i = 0; i < 4; i++) begin
          if (i == pos) begin
            if ($urandom_range(2) == 0) begin
              b = $urandom_range(1) ? QuoteCh : BslashCh;
            end else begin
              do b = 8'($urandom_range(255));
              while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
                     (b >= "A" && b <= "F"));
            end
          end else if ($urandom_range(3) == 0) begin
            b = 8'($urandom_range(255));
          end else begin
            b = hex_char(4'($urandom_range(15)));
          end
          add(b, 1'b0);
        end
      end
      2: begin
        add(BslashCh, 1'b0);
        add("u", 1'b0);
        repeat ($urandom_range(0, 3)) add(hex_char(4'($urandom_range(15))), 1'b0);
        add(8'($urandom_range(255)), 1'b1);
      end
      3: begin
        add(BslashCh, 1'b0);
        add(8'($urandom_range(255)), 1'b1);
      end
      default: begin
        // left open; the next string's start drops it
        add_plain();
        return;
      end
    endcase
    // trailing bytes after a final status are ignored
    repeat ($urandom_range(0, 2)) add(8'($urandom_range(255)), $urandom_range(3) == 0);
  endtask

  // Offer one input transaction, wait for acceptance, then predict
  task automatic offer(input stim_row_t r);
    if (!calm && $urandom_range(99) < 30) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push          <= 1'b1;
    in_byte_i     <= r.data;
    start_req_i   <= r.start;
    end_of_text_i <= r.eot;
    do @(posedge clk_i); while (full_q);
    n_sent++;
    unescape_step(r.data, r.start, r.eot);
    case (r.chk)
      CHK_PRED: pending_out = {pending_out, step_res};
      CHK_ONE:  pending_out = {pending_out, mk_res(r.t_data, r.t_status, 1'b1)};
      default:  ;
    endcase
  endtask

  // Main sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) offer(dir_tab[i]);

    for (int str_idx = 0; n_sent < NumItems; str_idx++) begin
      calm = (str_idx >= 10 && str_idx < 25);
      if (str_idx == 4) hold_req = 1'b1;
      stim_q.delete();
      gen_string();
      foreach (stim_q[i]) offer(stim_q[i]);
    end
    push <= 1'b0;

    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Result side: check each popped transaction, random pop with a long hold
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty_q) begin
        if (pending_out.size() == 0) begin
          if (n_fail < MaxReport) begin
            $display("unexpected result: byte %02h status %0d last %0b",
                     got_q.data, got_q.status, got_q.last);
          end
          n_fail++;
        end else if (got_q !== pending_out[0]) begin
          if (n_fail < MaxReport) begin
            $display("mismatch: exp byte %02h st %0d last %0b, got byte %02h st %0d last %0b",
                     pending_out[0].data, pending_out[0].status, pending_out[0].last,
                     got_q.data, got_q.status, got_q.last);
          end
          n_fail++;
          void'(pending_out.pop_front());
        end else begin
          void'(pending_out.pop_front());
        end
      end
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  // Watchdog
  initial begin
    #1000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
